// File: src/kwm_pkg.sv
// shared constants and types of the k-way sorted merge
package kwm_pkg;

   // storage geometry
   localparam int NUM_RUNS    = 8;
   localparam int RUN_DEPTH   = 128;
   localparam int VALUE_WIDTH = 32;

   // fixed field widths of the channels
   localparam int IDX_W  = 3;
   localparam int DATA_W = 32;

   localparam int RUN_W     = $clog2(NUM_RUNS);
   localparam int PTR_W     = $clog2(RUN_DEPTH);
   localparam int CNT_W     = $clog2(RUN_DEPTH + 1);
   localparam int MEM_DEPTH = NUM_RUNS * RUN_DEPTH;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // request kind codes
   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_POP  = 1'b1;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;
   typedef value_type head_array_type [NUM_RUNS];

   typedef struct packed {
      logic                     req_type;
      logic [IDX_W-1:0]         run_index;
      logic signed [DATA_W-1:0] push_value;
   } req_payload_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] out_value;
      logic [IDX_W-1:0]         out_run;
      logic                     valid_res;
      logic                     store_empty;
      logic                     push_dropped;
   } rsp_payload_type;

   // classified request as queued for the back end
   typedef struct packed {
      logic                          is_pop;
      logic                          in_range;
      logic [RUN_W-1:0]              run;
      logic signed [VALUE_WIDTH-1:0] value;
   } cmd_type;

   // winner of the head comparison
   typedef struct packed {
      logic                          found;
      logic [RUN_W-1:0]              run;
      logic signed [VALUE_WIDTH-1:0] value;
   } pick_type;

endpackage

// File: src/kwm_if.sv
// request and response channel interfaces
interface kwm_req_if;
   import kwm_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface kwm_rsp_if;
   import kwm_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: src/kwm_front.sv
// request decode and command queue feeding the back end
module kwm_front (
   input  logic             clock,
   input  logic             reset,
   kwm_req_if.sink          req_chan,
   output logic             cmd_valid,
   output kwm_pkg::cmd_type cmd,
   input  logic             cmd_ready
);
   import kwm_pkg::*;

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   fill_ff, fill_in;
   cmd_type             decoded;
   logic                do_write;
   logic                do_read;

   function automatic logic [QPTR_W-1:0] next_ptr(logic [QPTR_W-1:0] ptr);
      return (ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   always_comb begin
      decoded.is_pop   = (req_chan.data.req_type == REQ_POP);
      decoded.in_range = (int'(req_chan.data.run_index) < NUM_RUNS);
      decoded.run      = RUN_W'(req_chan.data.run_index);
      decoded.value    = VALUE_WIDTH'(req_chan.data.push_value);
   end

   assign req_chan.ready = (fill_ff != QCNT_W'(QUEUE_DEPTH));
   assign cmd_valid      = (fill_ff != '0);
   assign cmd            = entry_ff[rd_ptr_ff];

   assign do_write = req_chan.valid && req_chan.ready;
   assign do_read  = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = do_write ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_read ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_write && !do_read) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_read && !do_write) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         entry_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// File: src/kwm_min_tree.sv
// comparator tree picking the smallest live head, lowest run on ties
module kwm_min_tree (
   input  kwm_pkg::head_array_type      heads,
   input  logic [kwm_pkg::NUM_RUNS-1:0] live,
   output kwm_pkg::pick_type            pick
);
   import kwm_pkg::*;

   localparam int LEAVES = 1 << RUN_W;
   localparam int NODES  = 2 * LEAVES - 1;

   pick_type node [NODES];

   always_comb begin
      for (int i = 0; i < LEAVES; i++) begin
         if (i < NUM_RUNS) begin
            node[LEAVES - 1 + i].found = live[i];
            node[LEAVES - 1 + i].value = heads[i];
         end else begin
            node[LEAVES - 1 + i].found = 1'b0;
            node[LEAVES - 1 + i].value = '0;
         end
         node[LEAVES - 1 + i].run = RUN_W'(i);
      end
      // left child covers the lower runs, so it wins ties
      for (int n = LEAVES - 2; n >= 0; n--) begin
         if (node[2*n + 2].found &&
             (!node[2*n + 1].found || node[2*n + 2].value < node[2*n + 1].value)) begin
            node[n] = node[2*n + 2];
         end else begin
            node[n] = node[2*n + 1];
         end
      end
   end

   assign pick = node[0];

endmodule

// File: src/kwm_back.sv
// run storage, head cache, pointer bookkeeping and response register
module kwm_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         cmd_valid,
   input  kwm_pkg::cmd_type             cmd,
   output logic                         cmd_ready,
   output kwm_pkg::head_array_type      heads,
   output logic [kwm_pkg::NUM_RUNS-1:0] live,
   input  kwm_pkg::pick_type            pick,
   kwm_rsp_if.source                    rsp_chan
);
   import kwm_pkg::*;

   typedef enum logic [1:0] {
      ST_EXEC   = 2'b01,
      ST_REFILL = 2'b10
   } state_type;

   state_type         state_ff, state_in;
   logic [PTR_W-1:0]  head_ptr_ff [NUM_RUNS];
   logic [PTR_W-1:0]  head_ptr_in [NUM_RUNS];
   logic [PTR_W-1:0]  tail_ptr_ff [NUM_RUNS];
   logic [PTR_W-1:0]  tail_ptr_in [NUM_RUNS];
   logic [CNT_W-1:0]  count_ff [NUM_RUNS];
   logic [CNT_W-1:0]  count_in [NUM_RUNS];
   value_type         head_val_ff [NUM_RUNS];
   value_type         head_val_in [NUM_RUNS];
   logic [RUN_W-1:0]  refill_run_ff, refill_run_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_data_ff, rsp_data_in;

   value_type         run_mem [MEM_DEPTH];
   value_type         rd_data_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_raddr;

   logic              fire;
   logic              any_left;
   logic [PTR_W-1:0]  new_head;

   function automatic logic [PTR_W-1:0] advance(logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(RUN_DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   function automatic logic [ADDR_W-1:0] mem_addr(logic [RUN_W-1:0] run,
                                                  logic [PTR_W-1:0] ptr);
      return ADDR_W'(run) * ADDR_W'(RUN_DEPTH) + ADDR_W'(ptr);
   endfunction

   always_comb begin
      for (int r = 0; r < NUM_RUNS; r++) begin
         heads[r] = head_val_ff[r];
         live[r]  = (count_ff[r] != '0);
      end
   end

   // the head cache is reloaded in the refill cycle, so no request runs then
   assign cmd_ready = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_chan.ready);
   assign fire      = cmd_valid && cmd_ready;
   assign new_head  = advance(head_ptr_ff[pick.run]);

   always_comb begin
      state_in      = state_ff;
      head_ptr_in   = head_ptr_ff;
      tail_ptr_in   = tail_ptr_ff;
      count_in      = count_ff;
      head_val_in   = head_val_ff;
      refill_run_in = refill_run_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      mem_we        = 1'b0;
      mem_waddr     = mem_addr(cmd.run, tail_ptr_ff[cmd.run]);
      mem_re        = 1'b0;
      mem_raddr     = mem_addr(pick.run, new_head);
      any_left      = 1'b0;

      case (state_ff)
         ST_EXEC: begin
            if (fire) begin
               rsp_data_in = '0;
               if (!cmd.is_pop) begin
                  if (cmd.in_range && count_ff[cmd.run] != CNT_W'(RUN_DEPTH)) begin
                     mem_we                = 1'b1;
                     tail_ptr_in[cmd.run]  = advance(tail_ptr_ff[cmd.run]);
                     count_in[cmd.run]     = count_ff[cmd.run] + 1'b1;
                     // an empty run takes the value straight into its head slot
                     if (count_ff[cmd.run] == '0) begin
                        head_val_in[cmd.run] = cmd.value;
                     end
                  end else begin
                     rsp_data_in.push_dropped = 1'b1;
                  end
               end else if (pick.found) begin
                  head_ptr_in[pick.run] = new_head;
                  count_in[pick.run]    = count_ff[pick.run] - 1'b1;
                  rsp_data_in.out_value = DATA_W'(pick.value);
                  rsp_data_in.out_run   = IDX_W'(pick.run);
                  rsp_data_in.valid_res = 1'b1;
                  if (count_ff[pick.run] != CNT_W'(1)) begin
                     mem_re        = 1'b1;
                     refill_run_in = pick.run;
                     state_in      = ST_REFILL;
                  end
               end
               for (int r = 0; r < NUM_RUNS; r++) begin
                  any_left = any_left | (count_in[r] != '0);
               end
               rsp_data_in.store_empty = !any_left;
               rsp_valid_in            = 1'b1;
            end else if (rsp_chan.ready) begin
               rsp_valid_in = 1'b0;
            end
         end
         ST_REFILL: begin
            head_val_in[refill_run_ff] = rd_data_ff;
            state_in                   = ST_EXEC;
            if (rsp_chan.ready) begin
               rsp_valid_in = 1'b0;
            end
         end
         default: begin
            state_in = ST_EXEC;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_EXEC;
         rsp_valid_ff <= 1'b0;
         for (int r = 0; r < NUM_RUNS; r++) begin
            head_ptr_ff[r] <= '0;
            tail_ptr_ff[r] <= '0;
            count_ff[r]    <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ptr_ff  <= head_ptr_in;
         tail_ptr_ff  <= tail_ptr_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_val_ff   <= head_val_in;
      refill_run_ff <= refill_run_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         run_mem[mem_waddr] <= cmd.value;
      end
      if (mem_re) begin
         rd_data_ff <= run_mem[mem_raddr];
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

endmodule

// File: src/k_way_sorted_merge.sv
// k-way sorted merge top level
//
//   channel    dir   carries
//   req_chan   in    req_type, run_index, push_value
//   rsp_chan   out   out_value, out_run, valid_res, store_empty, push_dropped
//
// a push runs in the exec state; a pop adds the refill state when its run still holds
// entries: the winner leaves the head cache through the comparator tree, then the
// run's next entry comes back from the single-port-read run memory into the cache
// a two-entry command queue sits between request decode and execution
// synchronous reset empties every run; run memory needs no clearing
// a stalled response holds the back end, the queue keeps taking requests until full
module k_way_sorted_merge (
   input  logic      clock,
   input  logic      reset,
   kwm_req_if.sink   req_chan,
   kwm_rsp_if.source rsp_chan
);
   import kwm_pkg::*;

   logic                  cmd_valid;
   logic                  cmd_ready;
   cmd_type               cmd;
   head_array_type        heads;
   logic [NUM_RUNS-1:0]   live;
   pick_type              pick;

   kwm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_ready (cmd_ready)
   );

   kwm_min_tree u_min_tree (
      .heads (heads),
      .live  (live),
      .pick  (pick)
   );

   kwm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_ready (cmd_ready),
      .heads     (heads),
      .live      (live),
      .pick      (pick),
      .rsp_chan  (rsp_chan)
   );

endmodule
